// ===== rtl/core/lstp_pkg.sv =====
// Shared types, constants and arithmetic helpers for the lidar scan-to-point block.
// Used by every module under rtl/core; depends on nothing.
package lstp_pkg;

  localparam int SCAN_SAMPLES = 2048;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_LAT = CORDIC_STEPS + 1;
  localparam int IDX_W = 11;
  localparam int RANGE_W = 16;
  localparam int PT_W = 25;
  localparam int NUM_ATT = 3;

  localparam logic signed [63:0] PHASE_MUL = 64'sd42722830;
  localparam logic signed [23:0] HEIGHT_GATE = 24'sd500;
  localparam logic signed [63:0] OUT_MAX = 64'sd16777215;
  localparam logic signed [63:0] OUT_MIN = -64'sd16777216;

  typedef logic signed [33:0] cw_t;
  typedef logic signed [31:0] trig_t;

  localparam cw_t CORDIC_X0 = 34'sd652032874;
  localparam cw_t ATAN_TURNS [CORDIC_STEPS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
    34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
    34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861
  };

  typedef enum logic [2:0] {
    REG_START_ANGLE = 3'd0,
    REG_ANGLE_STEP  = 3'd1,
    REG_ROLL        = 3'd2,
    REG_PITCH       = 3'd3,
    REG_YAW         = 3'd4,
    REG_POS_X       = 3'd5,
    REG_POS_Y       = 3'd6,
    REG_POS_Z       = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [22:0] start_angle;
    logic [15:0]        angle_step;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
  } cfg_t;

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [PT_W-1:0] sat_pt(input logic signed [63:0] v);
    logic signed [PT_W-1:0] r;
    if (v > OUT_MAX) begin
      r = PT_W'(OUT_MAX);
    end else if (v < OUT_MIN) begin
      r = PT_W'(OUT_MIN);
    end else begin
      r = PT_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/lidar_scan_to_point_top.sv =====
// Top level of the lidar scan-to-point block: config port, front end, four CORDICs
// and the projection back end. Depends on lstp_pkg and all lstp_* modules.
//
//   Channel  Direction  Handshake          Payload
//   in_      slave      tvalid/tready      tdata: sample_index, range_mm
//   out_     master     tvalid/tready      tdata: point_x, point_y, point_z; tuser: point_valid
//   cfg_     slave      APB psel/penable   8 registers at byte addresses 0 to 28
//
// One request enters per cycle while the pipeline is not stalled; each request gives one result
// after two front-end stages, the 17-stage CORDIC, and five projection stages.
// The whole pipeline advances together whenever the output register is empty or taken,
// so a stall on the result side holds every stage and nothing is lost or repeated.
// Reset clears the stage valid bits and loads the register defaults.
module lidar_scan_to_point_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [10:0] sample_index, [26:11] range_mm, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [24:0] point_x, [49:25] point_y, [74:50] point_z
  output logic        out_tuser,  // [0] point_valid
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  lstp_pkg::cfg_t                  cfg;
  logic                            ce;
  logic                            f_occ, f_pv;
  logic [lstp_pkg::RANGE_W-1:0]    f_d;
  logic [31:0]                     ph_beam;
  logic [31:0]                     ph_att [lstp_pkg::NUM_ATT];
  lstp_pkg::trig_t                 sa, ca, sr, cr, sp, cp, sy, cy;
  logic                            occ_dl_r [lstp_pkg::CORDIC_LAT];
  logic                            pv_dl_r [lstp_pkg::CORDIC_LAT];
  logic [lstp_pkg::RANGE_W-1:0]    d_dl_r [lstp_pkg::CORDIC_LAT];
  logic signed [lstp_pkg::PT_W-1:0] px, py, pz;
  logic                            pvalid;

  assign ce = !out_tvalid || out_tready;
  assign in_tready = ce;

  lstp_cfg_regs u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready, .cfg(cfg)
  );

  lstp_front u_front (
    .clk, .rst_n, .ce,
    .in_valid(in_tvalid),
    .sample_index(in_tdata[10:0]),
    .range_mm(in_tdata[26:11]),
    .cfg(cfg),
    .occ(f_occ), .pv(f_pv), .range_o(f_d),
    .ph_beam(ph_beam), .ph_att(ph_att)
  );

  lstp_cordic u_cordic_beam  (.clk, .ce, .phase(ph_beam),   .sin_o(sa), .cos_o(ca));
  lstp_cordic u_cordic_roll  (.clk, .ce, .phase(ph_att[0]), .sin_o(sr), .cos_o(cr));
  lstp_cordic u_cordic_pitch (.clk, .ce, .phase(ph_att[1]), .sin_o(sp), .cos_o(cp));
  lstp_cordic u_cordic_yaw   (.clk, .ce, .phase(ph_att[2]), .sin_o(sy), .cos_o(cy));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lstp_pkg::CORDIC_LAT; i++) begin
        occ_dl_r[i] <= 1'b0;
      end
    end else if (ce) begin
      occ_dl_r[0] <= f_occ;
      for (int i = 1; i < lstp_pkg::CORDIC_LAT; i++) begin
        occ_dl_r[i] <= occ_dl_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pv_dl_r[0] <= f_pv;
      d_dl_r[0]  <= f_d;
      for (int i = 1; i < lstp_pkg::CORDIC_LAT; i++) begin
        pv_dl_r[i] <= pv_dl_r[i-1];
        d_dl_r[i]  <= d_dl_r[i-1];
      end
    end
  end

  lstp_proj u_proj (
    .clk, .rst_n, .ce,
    .occ(occ_dl_r[lstp_pkg::CORDIC_LAT-1]),
    .pv(pv_dl_r[lstp_pkg::CORDIC_LAT-1]),
    .range_mm(d_dl_r[lstp_pkg::CORDIC_LAT-1]),
    .sa, .ca, .sr, .cr, .sp, .cp, .sy, .cy,
    .cfg(cfg),
    .out_valid(out_tvalid),
    .point_valid(pvalid),
    .point_x(px), .point_y(py), .point_z(pz)
  );

  assign out_tdata = {5'd0, pz, py, px};
  assign out_tuser = pvalid;

endmodule

// ===== rtl/core/lstp_cfg_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on lstp_pkg for the register map and the configuration struct.
module lstp_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [4:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output lstp_pkg::cfg_t      cfg
);

  lstp_pkg::cfg_t   regs_r;
  lstp_pkg::reg_idx_t sel;
  logic             wr_en;

  assign sel = lstp_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.start_angle <= '0;
      regs_r.angle_step  <= 16'd4565;
      regs_r.roll_angle  <= '0;
      regs_r.pitch_angle <= '0;
      regs_r.yaw_angle   <= '0;
      regs_r.pos_x       <= '0;
      regs_r.pos_y       <= '0;
      regs_r.pos_z       <= '0;
    end else if (wr_en) begin
      unique case (sel)
        lstp_pkg::REG_START_ANGLE: regs_r.start_angle <= cfg_pwdata[22:0];
        lstp_pkg::REG_ANGLE_STEP:  regs_r.angle_step  <= cfg_pwdata[15:0];
        lstp_pkg::REG_ROLL:        regs_r.roll_angle  <= cfg_pwdata[15:0];
        lstp_pkg::REG_PITCH:       regs_r.pitch_angle <= cfg_pwdata[15:0];
        lstp_pkg::REG_YAW:         regs_r.yaw_angle   <= cfg_pwdata[15:0];
        lstp_pkg::REG_POS_X:       regs_r.pos_x       <= cfg_pwdata[23:0];
        lstp_pkg::REG_POS_Y:       regs_r.pos_y       <= cfg_pwdata[23:0];
        lstp_pkg::REG_POS_Z:       regs_r.pos_z       <= cfg_pwdata[23:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      lstp_pkg::REG_START_ANGLE: cfg_prdata = {9'd0, regs_r.start_angle};
      lstp_pkg::REG_ANGLE_STEP:  cfg_prdata = {16'd0, regs_r.angle_step};
      lstp_pkg::REG_ROLL:        cfg_prdata = {16'd0, regs_r.roll_angle};
      lstp_pkg::REG_PITCH:       cfg_prdata = {16'd0, regs_r.pitch_angle};
      lstp_pkg::REG_YAW:         cfg_prdata = {16'd0, regs_r.yaw_angle};
      lstp_pkg::REG_POS_X:       cfg_prdata = {8'd0, regs_r.pos_x};
      lstp_pkg::REG_POS_Y:       cfg_prdata = {8'd0, regs_r.pos_y};
      lstp_pkg::REG_POS_Z:       cfg_prdata = {8'd0, regs_r.pos_z};
    endcase
  end

endmodule

// ===== rtl/core/lstp_front.sv =====
// Front end: beam angle from the sample index, validity gate, and phase conversion
// of the beam and attitude angles over two register stages. Depends on lstp_pkg.
module lstp_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              ce,
  input  logic                              in_valid,
  input  logic [lstp_pkg::IDX_W-1:0]        sample_index,
  input  logic [lstp_pkg::RANGE_W-1:0]      range_mm,
  input  lstp_pkg::cfg_t                    cfg,
  output logic                              occ,
  output logic                              pv,
  output logic [lstp_pkg::RANGE_W-1:0]      range_o,
  output logic [31:0]                       ph_beam,
  output logic [31:0]                       ph_att [lstp_pkg::NUM_ATT]
);

  logic [26:0]                   step_prod;
  logic signed [28:0]            a_nxt;
  logic                          pv_nxt;
  logic signed [28:0]            a_r;
  logic                          occ1_r, pv1_r, occ2_r, pv2_r;
  logic [lstp_pkg::RANGE_W-1:0]  d1_r, d2_r;
  logic signed [63:0]            pb;
  logic signed [63:0]            pa [lstp_pkg::NUM_ATT];
  logic [31:0]                   phb_r;
  logic [31:0]                   pha_r [lstp_pkg::NUM_ATT];

  assign step_prod = 27'(sample_index) * 27'(cfg.angle_step);
  assign a_nxt = 29'(cfg.start_angle) + $signed({2'b00, step_prod});
  assign pv_nxt = !a_nxt[28] && (cfg.pos_z > lstp_pkg::HEIGHT_GATE) &&
                  (17'(sample_index) < 17'(lstp_pkg::SCAN_SAMPLES));

  assign pb = 64'(a_r) * lstp_pkg::PHASE_MUL;
  assign pa[0] = 64'(cfg.roll_angle) * lstp_pkg::PHASE_MUL;
  assign pa[1] = 64'(cfg.pitch_angle) * lstp_pkg::PHASE_MUL;
  assign pa[2] = 64'(cfg.yaw_angle) * lstp_pkg::PHASE_MUL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ1_r <= 1'b0;
      occ2_r <= 1'b0;
    end else if (ce) begin
      occ1_r <= in_valid;
      occ2_r <= occ1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a_r   <= a_nxt;
      pv1_r <= pv_nxt;
      d1_r  <= range_mm;
      pv2_r <= pv1_r;
      d2_r  <= d1_r;
      phb_r <= pb[47:16];
      for (int i = 0; i < lstp_pkg::NUM_ATT; i++) begin
        pha_r[i] <= pa[i][40:9];
      end
    end
  end

  assign occ = occ2_r;
  assign pv = pv2_r;
  assign range_o = d2_r;
  assign ph_beam = phb_r;
  assign ph_att = pha_r;

endmodule

// ===== rtl/core/lstp_cordic.sv =====
// Pipelined rotation-mode CORDIC: one quadrant fold stage, then one stage per step.
// Produces sine and cosine in Q2.30 from a 32-bit phase. Depends on lstp_pkg.
module lstp_cordic (
  input  logic                 clk,
  input  logic                 ce,
  input  logic [31:0]          phase,
  output lstp_pkg::trig_t      sin_o,
  output lstp_pkg::trig_t      cos_o
);

  lstp_pkg::cw_t x_r [lstp_pkg::CORDIC_LAT];
  lstp_pkg::cw_t y_r [lstp_pkg::CORDIC_LAT];
  lstp_pkg::cw_t z_r [lstp_pkg::CORDIC_LAT];
  logic          neg_r [lstp_pkg::CORDIC_LAT];
  lstp_pkg::cw_t z0;
  lstp_pkg::cw_t zf_nxt;
  logic          neg_nxt;

  assign z0 = 34'($signed(phase));

  always_comb begin
    if (z0 > 34'sd1073741824) begin
      zf_nxt  = z0 - 34'sd2147483648;
      neg_nxt = 1'b1;
    end else if (z0 < -34'sd1073741824) begin
      zf_nxt  = z0 + 34'sd2147483648;
      neg_nxt = 1'b1;
    end else begin
      zf_nxt  = z0;
      neg_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x_r[0]   <= lstp_pkg::CORDIC_X0;
      y_r[0]   <= '0;
      z_r[0]   <= zf_nxt;
      neg_r[0] <= neg_nxt;
    end
  end

  for (genvar i = 0; i < lstp_pkg::CORDIC_STEPS; i++) begin : g_step
    lstp_pkg::cw_t dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (ce) begin
        neg_r[i+1] <= neg_r[i];
        if (!z_r[i][33]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - lstp_pkg::ATAN_TURNS[i];
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + lstp_pkg::ATAN_TURNS[i];
        end
      end
    end
  end

  assign sin_o = neg_r[lstp_pkg::CORDIC_STEPS] ? 32'(-y_r[lstp_pkg::CORDIC_STEPS])
                                               : 32'(y_r[lstp_pkg::CORDIC_STEPS]);
  assign cos_o = neg_r[lstp_pkg::CORDIC_STEPS] ? 32'(-x_r[lstp_pkg::CORDIC_STEPS])
                                               : 32'(x_r[lstp_pkg::CORDIC_STEPS]);

endmodule

// ===== rtl/core/lstp_proj.sv =====
// Projection back end: polar to Cartesian, yaw, pitch and roll rotation, position
// offset, final sign flip and saturation over five register stages. Depends on lstp_pkg.
module lstp_proj (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            ce,
  input  logic                            occ,
  input  logic                            pv,
  input  logic [lstp_pkg::RANGE_W-1:0]    range_mm,
  input  lstp_pkg::trig_t                 sa, ca, sr, cr, sp, cp, sy, cy,
  input  lstp_pkg::cfg_t                  cfg,
  output logic                            out_valid,
  output logic                            point_valid,
  output logic signed [lstp_pkg::PT_W-1:0] point_x,
  output logic signed [lstp_pkg::PT_W-1:0] point_y,
  output logic signed [lstp_pkg::PT_W-1:0] point_z
);

  logic [4:0] occ_r, pv_r;
  logic signed [63:0] d64;
  logic signed [63:0] rs_r, tz_r, spsr_r, spcr_r, cpsr_r, cpcr_r;
  lstp_pkg::trig_t    sr1_r, cr1_r, sp1_r, cp1_r, sy1_r, cy1_r;
  lstp_pkg::trig_t    sr2_r, cr2_r, sp2_r, cp2_r;
  logic signed [63:0] tx_r, ty_r, tz2_r, spsr2_r, spcr2_r, cpsr2_r, cpcr2_r;
  logic signed [63:0] t_r [8];
  logic signed [63:0] wx_r, wy_r, wz_r;
  logic signed [lstp_pkg::PT_W-1:0] px_r, py_r, pz_r;

  assign d64 = 64'($signed({1'b0, range_mm}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (ce) begin
      occ_r <= {occ_r[3:0], occ};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pv_r <= {pv_r[3:0], pv};
      rs_r   <= lstp_pkg::rnd(d64 * 64'(sa), 14);
      tz_r   <= lstp_pkg::rnd(d64 * 64'(ca), 14);
      spsr_r <= lstp_pkg::rnd(64'(sp) * 64'(sr), 30);
      spcr_r <= lstp_pkg::rnd(64'(sp) * 64'(cr), 30);
      cpsr_r <= lstp_pkg::rnd(64'(cp) * 64'(sr), 30);
      cpcr_r <= lstp_pkg::rnd(64'(cp) * 64'(cr), 30);
      sr1_r <= sr; cr1_r <= cr; sp1_r <= sp; cp1_r <= cp; sy1_r <= sy; cy1_r <= cy;

      tx_r    <= lstp_pkg::rnd(rs_r * 64'(cy1_r), 30);
      ty_r    <= lstp_pkg::rnd(rs_r * 64'(sy1_r), 30);
      tz2_r   <= tz_r;
      spsr2_r <= spsr_r; spcr2_r <= spcr_r; cpsr2_r <= cpsr_r; cpcr2_r <= cpcr_r;
      sr2_r <= sr1_r; cr2_r <= cr1_r; sp2_r <= sp1_r; cp2_r <= cp1_r;

      t_r[0] <= lstp_pkg::rnd(64'(cp2_r) * tx_r, 30);
      t_r[1] <= lstp_pkg::rnd(spsr2_r * ty_r, 30);
      t_r[2] <= lstp_pkg::rnd(spcr2_r * tz2_r, 30);
      t_r[3] <= lstp_pkg::rnd(64'(cr2_r) * ty_r, 30);
      t_r[4] <= lstp_pkg::rnd(64'(sr2_r) * tz2_r, 30);
      t_r[5] <= lstp_pkg::rnd(64'(sp2_r) * tx_r, 30);
      t_r[6] <= lstp_pkg::rnd(cpsr2_r * ty_r, 30);
      t_r[7] <= lstp_pkg::rnd(cpcr2_r * tz2_r, 30);

      wx_r <= t_r[0] + t_r[1] + t_r[2] - (64'(cfg.pos_x) <<< 16);
      wy_r <= t_r[3] - t_r[4] - (64'(cfg.pos_y) <<< 16);
      wz_r <= t_r[7] + t_r[6] - t_r[5] - (64'(cfg.pos_z) <<< 16);

      if (pv_r[3]) begin
        px_r <= lstp_pkg::sat_pt(-lstp_pkg::rnd(wx_r, 16));
        py_r <= lstp_pkg::sat_pt(lstp_pkg::rnd(wy_r, 16));
        pz_r <= lstp_pkg::sat_pt(-lstp_pkg::rnd(wz_r, 16));
      end else begin
        px_r <= '0;
        py_r <= '0;
        pz_r <= '0;
      end
    end
  end

  assign out_valid = occ_r[4];
  assign point_valid = pv_r[4];
  assign point_x = px_r;
  assign point_y = py_r;
  assign point_z = pz_r;

endmodule
